// ----- rtl/core/lkc_pkg.sv -----
`timescale 1ns / 1ps

package lkc_pkg;

	// cache geometry
	localparam int MAX_ENTRIES = 16;
	localparam int KEY_BITS    = 64;

	// fixed field widths
	localparam int CAP_W  = 5;
	localparam int FILL_W = 5;

	// derived widths
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// broadcast from the control logic to every cell
	typedef struct packed {
		logic             go;
		logic             hit;
		logic             evict;
		logic [IDX_W-1:0] wr_pos;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

endpackage

// ----- rtl/core/lkc_cell.sv -----
`timescale 1ns / 1ps

module lkc_cell (
	input  logic                         clk,
	input  lkc_pkg::cell_ctrl_t          ctrl,
	input  logic [lkc_pkg::IDX_W-1:0]    idx,
	input  logic [lkc_pkg::KEY_BITS-1:0] access_key,
	input  logic [lkc_pkg::KEY_BITS-1:0] upper_key,
	input  logic                         seen_in,
	output logic                         seen_out,
	output logic [lkc_pkg::KEY_BITS-1:0] key_q
);

	logic valid;
	logic match;
	logic shift;

	// a cell is live when it sits below the fill count
	assign valid = ({{(lkc_pkg::CNT_W - lkc_pkg::IDX_W){1'b0}}, idx} < ctrl.count);
	assign match = valid && (key_q == access_key);

	// match at or below this cell, passed up the row
	assign seen_out = seen_in | match;

	// entries from the removed slot upward move down one place
	assign shift = ctrl.evict | (ctrl.hit & seen_out);

	// key storage
	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			if (idx == ctrl.wr_pos) begin
				key_q <= access_key;
			end else if (shift) begin
				key_q <= upper_key;
			end
		end
	end

endmodule

// ----- rtl/core/lru_key_cache.sv -----
`timescale 1ns / 1ps
// Fully associative least-recently-used cache of fixed-width keys.
// Requests: pulse start with access_key while busy is low; the request is
// taken at that clock edge. busy stays low, so a request may come every cycle.
// Each request gives one result in the next cycle: done is high for exactly one
// cycle with hit, evicted, evicted_key, fill_count, oldest_key, newest_key.
// The receiver cannot stall; results must be captured when done is high.
// Throughput: 1 request per cycle, set by the row of cells:
// every cell compares its key with the request at once, the match ripples up
// the row as a one-bit chain, and each cell loads, shifts or holds at the edge.
// Cell 0 holds the least recent key, cell fill_count-1 the most recent.
// Configuration: cap_we with cap_wdata sets the capacity (0 acts as 1, values
// above the cell count saturate); write it only while no request is in flight.
// Lowering it below the current fill drops nothing at once: a later miss
// evicts one key and keeps the fill unchanged.
// Reset (arst_n low) empties the cache and sets the capacity to 16; key cells
// are not cleared, as only cells below the fill count are ever used.
module lru_key_cache (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [lkc_pkg::KEY_BITS-1:0] access_key,
	input  logic                         cap_we,
	input  logic [lkc_pkg::CAP_W-1:0]    cap_wdata,
	output logic                         done,
	output logic                         hit,
	output logic                         evicted,
	output logic [lkc_pkg::KEY_BITS-1:0] evicted_key,
	output logic [lkc_pkg::FILL_W-1:0]   fill_count,
	output logic [lkc_pkg::KEY_BITS-1:0] oldest_key,
	output logic [lkc_pkg::KEY_BITS-1:0] newest_key
);

	localparam int N = lkc_pkg::MAX_ENTRIES;

	logic [lkc_pkg::CAP_W-1:0]    cap_q;
	logic [lkc_pkg::CNT_W-1:0]    count_q;
	logic [lkc_pkg::CNT_W-1:0]    eff_cap;
	logic [lkc_pkg::CNT_W-1:0]    count_nxt;
	logic [lkc_pkg::KEY_BITS-1:0] cell_key [N];
	logic [N:0]                   seen;
	logic                         go;
	logic                         any_hit;
	logic                         append;
	logic                         evict;
	lkc_pkg::cell_ctrl_t          ctrl;

	logic                         done_q;
	logic                         hit_q;
	logic                         evicted_q;
	logic [lkc_pkg::KEY_BITS-1:0] evicted_key_q;
	logic [lkc_pkg::KEY_BITS-1:0] newest_q;

	// every request is applied at the edge that takes it, so busy is never raised
	assign busy = 1'b0;
	assign go   = start & ~busy;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkc_pkg::CAP_RESET;
		end else if (cap_we) begin
			cap_q <= cap_wdata;
		end
	end

	// effective capacity, clamped to one..cell count
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lkc_pkg::CNT_W'(1);
		end else if (32'(cap_q) > 32'(N)) begin
			eff_cap = lkc_pkg::CNT_W'(N);
		end else begin
			eff_cap = lkc_pkg::CNT_W'(cap_q);
		end
	end

	// hit, append or evict decision
	assign any_hit = seen[N];
	assign append  = ~any_hit & (count_q < eff_cap);
	assign evict   = ~any_hit & ~append;

	always_comb begin
		ctrl.go    = go;
		ctrl.hit   = any_hit;
		ctrl.evict = evict;
		ctrl.count = count_q;
		if (append) begin
			ctrl.wr_pos = lkc_pkg::IDX_W'(count_q);
		end else begin
			ctrl.wr_pos = lkc_pkg::IDX_W'(count_q - lkc_pkg::CNT_W'(1));
		end
		count_nxt = append ? count_q + lkc_pkg::CNT_W'(1) : count_q;
	end

	// row of cells, cell 0 least recent
	assign seen[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [lkc_pkg::KEY_BITS-1:0] upper;

		if (i + 1 < N) begin : g_up
			assign upper = cell_key[i + 1];
		end else begin : g_top
			assign upper = '0;
		end

		lkc_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.idx        (lkc_pkg::IDX_W'(i)),
			.access_key (access_key),
			.upper_key  (upper),
			.seen_in    (seen[i]),
			.seen_out   (seen[i + 1]),
			.key_q      (cell_key[i])
		);
	end

	// fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= go;
			if (go) begin
				count_q <= count_nxt;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (go) begin
			hit_q         <= any_hit;
			evicted_q     <= evict;
			evicted_key_q <= evict ? cell_key[0] : '0;
			newest_q      <= access_key;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign fill_count  = lkc_pkg::FILL_W'(count_q);
	assign oldest_key  = cell_key[0];
	assign newest_key  = newest_q;

endmodule

// ----- rtl/core/lkc_checker.sv -----
`timescale 1ns / 1ps

module lkc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [lkc_pkg::KEY_BITS-1:0] access_key,
	input logic                         done,
	input logic                         hit,
	input logic                         evicted,
	input logic [lkc_pkg::KEY_BITS-1:0] evicted_key,
	input logic [lkc_pkg::FILL_W-1:0]   fill_count,
	input logic [lkc_pkg::KEY_BITS-1:0] newest_key
);

	// every request gives a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("request without result");

	// newest key is the key of the request
	a_newest: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> newest_key == $past(access_key))
		else $error("newest key differs from request");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted))
		else $error("hit and eviction together");

	// evicted key reads zero without eviction
	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !evicted |-> evicted_key == '0)
		else $error("evicted key not zero");

	// fill is at least one and within the row after any request
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fill_count != '0 &&
			32'(fill_count) <= 32'(lkc_pkg::MAX_ENTRIES))
		else $error("fill count out of range");

endmodule

bind lru_key_cache lkc_checker u_lkc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.access_key  (access_key),
	.done        (done),
	.hit         (hit),
	.evicted     (evicted),
	.evicted_key (evicted_key),
	.fill_count  (fill_count),
	.newest_key  (newest_key)
);

// ----- verif/lru_key_cache_test.sv -----
`timescale 1ns / 1ps

module lru_key_cache_test;
	import lkc_pkg::*;

	typedef logic [KEY_BITS-1:0] key_t;

	// one result as the block reports it
	typedef struct packed {
		logic              hit;
		logic              evicted;
		key_t              evicted_key;
		logic [FILL_W-1:0] fill_count;
		key_t              oldest_key;
		key_t              newest_key;
	} access_result_t;

	typedef enum logic {ROW_CAP, ROW_ACCESS} row_kind_t;

	// one row of the directed table
	typedef struct {
		row_kind_t      kind;
		key_t           value;
		bit             typed;
		access_result_t want;
	} row_t;

	localparam key_t KEY_ONES   = '1;
	localparam key_t KEY_MSB    = key_t'(1) << (KEY_BITS - 1);
	localparam int   STALL_MAX  = 2000;
	localparam int   PHASES     = 13;
	localparam int   PHASE_REQS = 150;
	localparam int   POOL_MAX   = 24;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	key_t              access_key;
	logic              cap_we;
	logic [CAP_W-1:0]  cap_wdata;
	logic              done;
	logic              hit;
	logic              evicted;
	key_t              evicted_key;
	logic [FILL_W-1:0] fill_count;
	key_t              oldest_key;
	key_t              newest_key;

	// mirror of the cache contents, cell 0 least recent
	key_t             lru_keys[MAX_ENTRIES];
	int               lru_fill = 0;
	logic [CAP_W-1:0] lru_cap  = CAP_RESET;

	access_result_t pending_results[$];
	int             n_fail       = 0;
	int             stall_cycles = 0;
	bit             idle_on      = 1;

	lru_key_cache dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.access_key  (access_key),
		.cap_we      (cap_we),
		.cap_wdata   (cap_wdata),
		.done        (done),
		.hit         (hit),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.fill_count  (fill_count),
		.oldest_key  (oldest_key),
		.newest_key  (newest_key)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one access to the mirror and return what the block should report
	function automatic access_result_t predict_access(key_t k);
		access_result_t r;
		int lim;
		int pos;
		r   = '0;
		pos = -1;
		lim = (lru_cap == 0) ? 1 : ((lru_cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(lru_cap));
		for (int i = 0; i < lru_fill; i++)
			if (pos < 0 && lru_keys[i] == k)
				pos = i;
		if (pos >= 0) begin
			r.hit = 1'b1;
			for (int i = pos; i < lru_fill - 1; i++)
				lru_keys[i] = lru_keys[i + 1];
			lru_keys[lru_fill - 1] = k;
		end else if (lru_fill < lim) begin
			lru_keys[lru_fill] = k;
			lru_fill++;
		end else begin
			// full, or capacity lowered below the fill: drop one, keep the fill
			r.evicted     = 1'b1;
			r.evicted_key = lru_keys[0];
			for (int i = 0; i < lru_fill - 1; i++)
				lru_keys[i] = lru_keys[i + 1];
			lru_keys[lru_fill - 1] = k;
		end
		r.fill_count = FILL_W'(lru_fill);
		r.oldest_key = lru_keys[0];
		r.newest_key = lru_keys[lru_fill - 1];
		return r;
	endfunction

	function automatic row_t cap_row(int v);
		row_t r;
		r.kind  = ROW_CAP;
		r.value = key_t'(v);
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic row_t acc_row(key_t k);
		row_t r;
		r.kind  = ROW_ACCESS;
		r.value = k;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic row_t acc_want(key_t k, logic h, logic e, key_t ek,
			logic [FILL_W-1:0] f, key_t o, key_t n);
		row_t r;
		r       = acc_row(k);
		r.typed = 1'b1;
		r.want  = '{h, e, ek, f, o, n};
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			n_fail++;
		end
	endfunction

	// drive one request, with random idle cycles ahead of it while idle_on is set
	task automatic send_access(key_t k, bit typed, access_result_t want);
		bit             gap;
		access_result_t r;
		do begin
			@(negedge clk);
			gap = idle_on && ($urandom_range(99) < 21);
			start      <= !gap;
			access_key <= k;
		end while (gap);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = predict_access(k);
		pending_results.push_back(typed ? want : r);
	endtask

	// capacity changes only once the cache has gone quiet
	task automatic write_capacity(logic [CAP_W-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
		@(negedge clk);
		cap_we    <= 1'b1;
		cap_wdata <= v;
		@(posedge clk);
		lru_cap = v;
		@(negedge clk);
		cap_we <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		access_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				check_field("hit", 64'(want.hit), 64'(hit));
				check_field("evicted", 64'(want.evicted), 64'(evicted));
				check_field("evicted_key", 64'(want.evicted_key), 64'(evicted_key));
				check_field("fill_count", 64'(want.fill_count), 64'(fill_count));
				check_field("oldest_key", 64'(want.oldest_key), 64'(oldest_key));
				check_field("newest_key", 64'(want.newest_key), 64'(newest_key));
			end
		end
	end

	// watchdog on cycles with no progress
	always @(posedge clk) begin
		if ((start && !busy) || done || cap_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_MAX) begin
			$display("** lru_key_cache: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		row_t             dir_table[$];
		key_t             key_pool[POOL_MAX];
		int               cap_plan[PHASES - 2];
		int               pool_n;
		key_t             k;
		logic [CAP_W-1:0] cv;

		arst_n     = 1'b0;
		start      = 1'b0;
		access_key = '0;
		cap_we     = 1'b0;
		cap_wdata  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: single-entry cache, zero and saturated capacity, front-to-rear move,
		// capacity lowered below the fill
		dir_table = '{
			cap_row(1),
			acc_want('0, 1'b0, 1'b0, '0, 1, '0, '0),
			acc_want(KEY_ONES, 1'b0, 1'b1, '0, 1, KEY_ONES, KEY_ONES),
			acc_want(KEY_ONES, 1'b1, 1'b0, '0, 1, KEY_ONES, KEY_ONES),
			cap_row(0),
			acc_want(key_t'(5), 1'b0, 1'b1, KEY_ONES, 1, key_t'(5), key_t'(5)),
			cap_row(16),
			acc_want('0, 1'b0, 1'b0, '0, 2, key_t'(5), '0),
			acc_want(KEY_MSB, 1'b0, 1'b0, '0, 3, key_t'(5), KEY_MSB),
			acc_want(key_t'(5), 1'b1, 1'b0, '0, 3, '0, key_t'(5)),
			acc_row(KEY_MSB),
			acc_row(key_t'(64'h0123_4567_89ab_cdef)),
			cap_row(2),
			acc_row(key_t'(9)),
			acc_row(key_t'(64'h0123_4567_89ab_cdef)),
			acc_row(key_t'(64'h5555_5555_5555_5555)),
			cap_row(31),
			acc_row(key_t'(64'haaaa_aaaa_aaaa_aaaa)),
			acc_row(key_t'(64'haaaa_aaaa_aaaa_aaaa)),
			acc_row(KEY_ONES)
		};
		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_CAP)
				write_capacity(CAP_W'(dir_table[i].value));
			else
				send_access(dir_table[i].value, dir_table[i].typed, dir_table[i].want);
		end

		// random phases: keys mostly from a small pool so hits and evictions mix
		cap_plan = '{16, 1, 0, 31, 5, 2, 12, 17, 3, 8, 15};
		for (int p = 0; p < PHASES; p++) begin
			cv = (p < PHASES - 2) ? CAP_W'(cap_plan[p]) : CAP_W'($urandom_range(31));
			write_capacity(cv);
			pool_n = $urandom_range(1, POOL_MAX);
			for (int i = 0; i < POOL_MAX; i++)
				key_pool[i] = {$urandom, $urandom};
			// one phase runs back to back with no idle cycles
			idle_on = (p != 4);
			repeat (PHASE_REQS) begin
				if ($urandom_range(9) == 0)
					k = {$urandom, $urandom};
				else
					k = key_pool[$urandom_range(pool_n - 1)];
				send_access(k, 1'b0, '0);
			end
		end

		// drain
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (n_fail == 0)
			$display("** lru_key_cache: PASSED **");
		else
			$display("** lru_key_cache: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/lkc_pkg.sv
rtl/core/lkc_cell.sv
rtl/core/lru_key_cache.sv
rtl/core/lkc_checker.sv
verif/lru_key_cache_test.sv
